>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ldpvp_pkg.sv
package ldpvp_pkg;

   localparam int GRAD_W      = 32;
   localparam int RAND_W      = 32;
   localparam int CSR_DATA_W  = 33;
   localparam int CSR_INDEX_W = 3;
   localparam int X_W         = 18;
   localparam int TP_W        = 50;
   localparam int PM_W        = 51;
   localparam int OFF_W       = 53;
   localparam int G_W         = 35;

   localparam int Q_ONE = 65536;

   localparam logic signed [GRAD_W-1:0] GRAD_MAX = 32'sd65536;
   localparam logic signed [GRAD_W-1:0] GRAD_MIN = -32'sd65536;
   localparam logic signed [X_W-1:0]    X_MAX    = 18'sd65536;
   localparam logic signed [X_W-1:0]    X_MIN    = -18'sd65536;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   localparam logic signed [35:0] P_HALF = 36'sh0_8000_0000;
   localparam logic signed [35:0] P_FULL = 36'sh1_0000_0000;

   localparam logic        RST_MECH_SELECT  = 1'b1;
   localparam logic [32:0] RST_HYBRID_PROB  = 33'h1_0000_0000;
   localparam logic [31:0] RST_TP_MAGNITUDE = 32'd131072;
   localparam logic [31:0] RST_TP_SLOPE     = 32'd1073741824;
   localparam logic [31:0] RST_PM_BOUND     = 32'd196608;
   localparam logic [30:0] RST_PM_EDGE      = 31'd536870912;
   localparam logic [31:0] RST_PM_CENTER    = 32'd2147483648;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MECHANISM_SELECT = 3'd0,
      CSR_HYBRID_PROB      = 3'd1,
      CSR_TP_MAGNITUDE     = 3'd2,
      CSR_TP_SLOPE         = 3'd3,
      CSR_PM_BOUND         = 3'd4,
      CSR_PM_EDGE_SCALE    = 3'd5,
      CSR_PM_CENTER_PROB   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      INTV_LEFT   = 2'd0,
      INTV_CENTER = 2'd1,
      INTV_RIGHT  = 2'd2
   } interval_type;

endpackage

>>> sv/ldp_value_perturbation.sv
// Local differential privacy perturbation of one signed Q16.16 value, clamped
// to [-1,1], by the piecewise mechanism or the hybrid mechanism (two-point or
// piecewise, chosen by rand_hybrid against a configured probability). Six
// register stages: clamp and branch pick, the three input multipliers,
// interval bounds and choice, interval width, the position multiply, and the
// final add with Q16.16 saturation in the output register. One beat can enter
// every cycle while the output is taken or a stage is empty; a waiting
// result stalls only the stages behind it, so empty stages keep filling.
// Configuration is written by index and takes effect at once; write it only
// while no beat is in flight.
`include "assert_macros.svh"

module ldp_value_perturbation
   import ldpvp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [GRAD_W-1:0]     req_gradient_value,
   input  logic        [RAND_W-1:0]     req_rand_choice,
   input  logic        [RAND_W-1:0]     req_rand_position,
   input  logic        [RAND_W-1:0]     req_rand_hybrid,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [GRAD_W-1:0]     rsp_perturbed_value,
   output logic                         rsp_used_two_point,
   input  logic                         csr_we,
   input  logic        [CSR_INDEX_W-1:0] csr_index,
   input  logic        [CSR_DATA_W-1:0]  csr_wdata
);

   logic        mech_select_ff;
   logic [32:0] hybrid_prob_ff;
   logic [31:0] tp_magnitude_ff;
   logic [31:0] tp_slope_ff;
   logic [31:0] pm_bound_ff;
   logic [30:0] pm_edge_scale_ff;
   logic [31:0] pm_center_prob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mech_select_ff    <= RST_MECH_SELECT;
         hybrid_prob_ff    <= RST_HYBRID_PROB;
         tp_magnitude_ff   <= RST_TP_MAGNITUDE;
         tp_slope_ff       <= RST_TP_SLOPE;
         pm_bound_ff       <= RST_PM_BOUND;
         pm_edge_scale_ff  <= RST_PM_EDGE;
         pm_center_prob_ff <= RST_PM_CENTER;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MECHANISM_SELECT: mech_select_ff    <= csr_wdata[0];
            CSR_HYBRID_PROB:      hybrid_prob_ff    <= csr_wdata;
            CSR_TP_MAGNITUDE:     tp_magnitude_ff   <= csr_wdata[31:0];
            CSR_TP_SLOPE:         tp_slope_ff       <= csr_wdata[31:0];
            CSR_PM_BOUND:         pm_bound_ff       <= csr_wdata[31:0];
            CSR_PM_EDGE_SCALE:    pm_edge_scale_ff  <= csr_wdata[30:0];
            CSR_PM_CENTER_PROB:   pm_center_prob_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when it is empty or the next one loads
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6       = !rsp_valid_ff || rsp_ready;
   assign en5       = !s5_valid_ff || en6;
   assign en4       = !s4_valid_ff || en5;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= req_valid;
         if (en2) s2_valid_ff  <= s1_valid_ff;
         if (en3) s3_valid_ff  <= s2_valid_ff;
         if (en4) s4_valid_ff  <= s3_valid_ff;
         if (en5) s5_valid_ff  <= s4_valid_ff;
         if (en6) rsp_valid_ff <= s5_valid_ff;
      end
   end

   // stage 1: clamp, pick branch
   logic signed [X_W-1:0] s1_x_in, s1_x_ff;
   logic                  s1_two_in, s1_two_ff;
   logic [RAND_W-1:0]     s1_rc_ff, s1_rp_ff;

   always_comb begin
      priority if (req_gradient_value > GRAD_MAX) begin
         s1_x_in = X_MAX;
      end else if (req_gradient_value < GRAD_MIN) begin
         s1_x_in = X_MIN;
      end else begin
         s1_x_in = req_gradient_value[X_W-1:0];
      end
      s1_two_in = mech_select_ff && ({1'b0, req_rand_hybrid} <= hybrid_prob_ff);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_x_ff   <= s1_x_in;
         s1_two_ff <= s1_two_in;
         s1_rc_ff  <= req_rand_choice;
         s1_rp_ff  <= req_rand_position;
      end
   end

   // stage 2: multipliers
   logic signed [TP_W:0]   tp_full;
   logic [X_W-1:0]         x_bias;
   logic [48:0]            edge_full;
   logic [32:0]            c_bias;
   logic signed [PM_W:0]   pm_full;
   logic signed [TP_W-1:0] s2_tp_in, s2_tp_ff;
   logic [32:0]            s2_p1_in, s2_p1_ff;
   logic signed [PM_W-1:0] s2_pm_in, s2_pm_ff;
   logic                   s2_two_ff;
   logic [RAND_W-1:0]      s2_rc_ff, s2_rp_ff;

   always_comb begin
      tp_full   = (TP_W+1)'(s1_x_ff) * (TP_W+1)'($signed({1'b0, tp_slope_ff}));
      x_bias    = s1_x_ff + X_MAX;
      edge_full = 49'(x_bias) * 49'(pm_edge_scale_ff);
      c_bias    = 33'(pm_bound_ff) + 33'(Q_ONE);
      pm_full   = (PM_W+1)'(s1_x_ff) * (PM_W+1)'($signed({1'b0, c_bias}));
      s2_tp_in  = tp_full[TP_W-1:0];
      s2_p1_in  = edge_full[48:16];
      s2_pm_in  = pm_full[PM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_tp_ff  <= s2_tp_in;
         s2_p1_ff  <= s2_p1_in;
         s2_pm_ff  <= s2_pm_in;
         s2_two_ff <= s1_two_ff;
         s2_rc_ff  <= s1_rc_ff;
         s2_rp_ff  <= s1_rp_ff;
      end
   end

   // stage 3: two-point sign, interval edges, interval choice
   logic signed [TP_W-1:0]  tp_shr;
   logic signed [35:0]      p_raw;
   logic [32:0]             p_clamp;
   logic [31:0]             mag_pos, mag_neg;
   logic signed [33:0]      c_less;
   logic signed [OFF_W-1:0] off, pm_ext, d1, d2, d1_shr, d2_shr;
   logic [33:0]             thr2;
   logic [31:0]             s3_tp_res_in, s3_tp_res_ff;
   logic signed [G_W-1:0]   s3_g1_in, s3_g1_ff, s3_g2_in, s3_g2_ff;
   interval_type            s3_intv_in, s3_intv_ff;
   logic                    s3_two_ff;
   logic [RAND_W-1:0]       s3_rp_ff;

   always_comb begin
      tp_shr = s2_tp_ff >>> 16;
      p_raw  = $signed(tp_shr[35:0]) + P_HALF;
      priority if (p_raw < 0) begin
         p_clamp = '0;
      end else if (p_raw > P_FULL) begin
         p_clamp = P_FULL[32:0];
      end else begin
         p_clamp = p_raw[32:0];
      end
      mag_pos = tp_magnitude_ff[31] ? SAT_MAX : tp_magnitude_ff;
      mag_neg = (tp_magnitude_ff > SAT_MIN) ? SAT_MIN : (~tp_magnitude_ff + 32'd1);
      s3_tp_res_in = ({1'b0, s2_rc_ff} <= p_clamp) ? mag_pos : mag_neg;

      c_less   = $signed({2'b00, pm_bound_ff}) - 34'(Q_ONE);
      off      = {{3{c_less[33]}}, c_less, 16'h0000};
      pm_ext   = OFF_W'(s2_pm_ff);
      d1       = pm_ext - off;
      d2       = pm_ext + off;
      d1_shr   = d1 >>> 17;
      d2_shr   = d2 >>> 17;
      s3_g1_in = d1_shr[G_W-1:0];
      s3_g2_in = d2_shr[G_W-1:0];

      thr2 = 34'(s2_p1_ff) + 34'(pm_center_prob_ff);
      priority if ({1'b0, s2_rc_ff} < s2_p1_ff) begin
         s3_intv_in = INTV_LEFT;
      end else if ({2'b00, s2_rc_ff} < thr2) begin
         s3_intv_in = INTV_CENTER;
      end else begin
         s3_intv_in = INTV_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_tp_res_ff <= s3_tp_res_in;
         s3_g1_ff     <= s3_g1_in;
         s3_g2_ff     <= s3_g2_in;
         s3_intv_ff   <= s3_intv_in;
         s3_two_ff    <= s2_two_ff;
         s3_rp_ff     <= s2_rp_ff;
      end
   end

   // stage 4: interval ends and width
   logic signed [G_W-1:0] c_ext, lo, hi;
   logic signed [G_W:0]   span;
   logic [G_W-1:0]        s4_w_in, s4_w_ff;
   logic signed [G_W-1:0] s4_lo_ff;
   logic [31:0]           s4_tp_res_ff;
   logic                  s4_two_ff;
   logic [RAND_W-1:0]     s4_rp_ff;

   always_comb begin
      c_ext = $signed({3'b000, pm_bound_ff});
      unique case (s3_intv_ff)
         INTV_LEFT: begin
            lo = -c_ext;
            hi = s3_g1_ff;
         end
         INTV_CENTER: begin
            lo = s3_g1_ff;
            hi = s3_g2_ff;
         end
         INTV_RIGHT: begin
            lo = s3_g2_ff;
            hi = c_ext;
         end
         default: begin
            lo = s3_g1_ff;
            hi = s3_g2_ff;
         end
      endcase
      span    = (G_W+1)'(hi) - (G_W+1)'(lo);
      s4_w_in = (span > 0) ? span[G_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_w_ff      <= s4_w_in;
         s4_lo_ff     <= lo;
         s4_tp_res_ff <= s3_tp_res_ff;
         s4_two_ff    <= s3_two_ff;
         s4_rp_ff     <= s3_rp_ff;
      end
   end

   // stage 5: position inside the interval
   logic [63:0]           plo_full;
   logic [31:0]           s5_plo_in, s5_plo_ff;
   logic [34:0]           s5_phi_in, s5_phi_ff;
   logic signed [G_W-1:0] s5_lo_ff;
   logic [31:0]           s5_tp_res_ff;
   logic                  s5_two_ff;

   always_comb begin
      plo_full  = 64'(s4_w_ff[31:0]) * 64'(s4_rp_ff);
      s5_plo_in = plo_full[63:32];
      s5_phi_in = 35'(s4_w_ff[G_W-1:32]) * 35'(s4_rp_ff);
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_plo_ff    <= s5_plo_in;
         s5_phi_ff    <= s5_phi_in;
         s5_lo_ff     <= s4_lo_ff;
         s5_tp_res_ff <= s4_tp_res_ff;
         s5_two_ff    <= s4_two_ff;
      end
   end

   // stage 6: add, saturate, select
   logic [35:0]        pos;
   logic signed [36:0] r_full;
   logic [31:0]        pw_sat;
   logic [31:0]        rsp_value_in, rsp_value_ff;
   logic               rsp_two_ff;

   always_comb begin
      pos    = 36'(s5_phi_ff) + 36'(s5_plo_ff);
      r_full = 37'(s5_lo_ff) + $signed({1'b0, pos});
      priority if (r_full > 37'sd2147483647) begin
         pw_sat = SAT_MAX;
      end else if (r_full < -37'sd2147483648) begin
         pw_sat = SAT_MIN;
      end else begin
         pw_sat = r_full[31:0];
      end
      rsp_value_in = s5_two_ff ? s5_tp_res_ff : pw_sat;
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         rsp_value_ff <= rsp_value_in;
         rsp_two_ff   <= s5_two_ff;
      end
   end

   assign rsp_perturbed_value = $signed(rsp_value_ff);
   assign rsp_used_two_point  = rsp_two_ff;

   `ASSERT_IMPLIES(a_two_point_only_hybrid, clock, reset, rsp_valid_ff && rsp_two_ff, mech_select_ff, "two-point beat in piecewise-only mode")
   `ASSERT_IMPLIES(a_two_point_value, clock, reset, rsp_valid_ff && rsp_two_ff, rsp_value_ff == mag_pos || rsp_value_ff == mag_neg, "two-point beat is not plus or minus the magnitude")
   `ASSERT_IMPLIES(a_piecewise_bound, clock, reset, rsp_valid_ff && !rsp_two_ff && !pm_bound_ff[31] && pm_bound_ff >= 32'(Q_ONE), rsp_perturbed_value <= $signed(pm_bound_ff) && rsp_perturbed_value >= -$signed(pm_bound_ff), "piecewise beat outside the bound")
   `ASSERT_NEXT(a_last_stage_advance, clock, reset, s5_valid_ff && en6, rsp_valid_ff, "beat dropped at the output register")

endmodule

>>> verif/ldp_value_perturbation_tb.sv
`timescale 1ns / 100ps

module ldp_value_perturbation_tb;
   import ldpvp_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int NUM_PHASES = 10;
   localparam int BEATS_PER_PHASE = 145;
   localparam int SETTLE_CYCLES = 10;

   typedef struct packed {
      logic signed [GRAD_W-1:0] value;
      logic                     two_point;
   } perturbation_type;

   typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]    data;
      logic [GRAD_W-1:0]        grad;
      logic [RAND_W-1:0]        rc;
      logic [RAND_W-1:0]        rp;
      logic [RAND_W-1:0]        rh;
      bit                       typed;
      logic [GRAD_W-1:0]        report;
      bit                       two_point;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [GRAD_W-1:0] req_gradient_value = '0;
   logic [RAND_W-1:0]        req_rand_choice = '0;
   logic [RAND_W-1:0]        req_rand_position = '0;
   logic [RAND_W-1:0]        req_rand_hybrid = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [GRAD_W-1:0] rsp_perturbed_value;
   logic                     rsp_used_two_point;
   logic                     csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   logic        cfg_mech = RST_MECH_SELECT;
   logic [32:0] cfg_hybrid_prob = RST_HYBRID_PROB;
   logic [31:0] cfg_tp_mag = RST_TP_MAGNITUDE;
   logic [31:0] cfg_tp_slope = RST_TP_SLOPE;
   logic [31:0] cfg_pm_bound = RST_PM_BOUND;
   logic [30:0] cfg_pm_edge = RST_PM_EDGE;
   logic [31:0] cfg_pm_center = RST_PM_CENTER;

   perturbation_type expected_reports[$];
   int               mismatch_count = 0;

   stim_row_type directed_rows [27] = '{
      '{ROW_BEAT, '0, '0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 1, 32'h0002_0000, 1},
      '{ROW_BEAT, '0, '0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1,
        32'hFFFE_0000, 1},
      '{ROW_BEAT, '0, '0, 32'h0, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000, 1,
        32'h0002_0000, 1},
      '{ROW_BEAT, '0, '0, 32'h0, 32'h8000_0001, 32'h0, 32'hFFFF_FFFF, 1, 32'hFFFE_0000, 1},
      '{ROW_WRITE, CSR_SPARE_INDEX, 33'h0, '0, '0, '0, '0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 32'h0002_0000, 1},
      '{ROW_WRITE, CSR_MECHANISM_SELECT, 33'h0, '0, '0, '0, '0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1, 32'hFFFD_0000, 0},
      '{ROW_BEAT, '0, '0, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h0, 32'h2000_0000, 32'h8000_0000, 32'h0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h0, 32'h1FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h0, 32'h9FFF_FFFF, 32'h5555_5555, 32'h0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h0, 32'hA000_0000, 32'hAAAA_AAAA, 32'h0, 0, '0, 0},
      '{ROW_WRITE, CSR_PM_BOUND, 33'h0, '0, '0, '0, '0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h0001_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h0, 0, '0, 0},
      '{ROW_WRITE, CSR_PM_BOUND, 33'h0_FFFF_FFFF, '0, '0, '0, '0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 0, '0, 0},
      '{ROW_WRITE, CSR_MECHANISM_SELECT, 33'h1, '0, '0, '0, '0, 0, '0, 0},
      '{ROW_WRITE, CSR_HYBRID_PROB, 33'h0, '0, '0, '0, '0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h0000_8000, 32'h0, 32'h0, 32'h0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'hFFFF_8000, 32'h0, 32'h0, 32'h1, 0, '0, 0},
      '{ROW_WRITE, CSR_TP_MAGNITUDE, 33'h0_FFFF_FFFF, '0, '0, '0, '0, 0, '0, 0},
      '{ROW_WRITE, CSR_TP_SLOPE, 33'h0_FFFF_FFFF, '0, '0, '0, '0, 0, '0, 0},
      '{ROW_BEAT, '0, '0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, 32'h7FFF_FFFF, 1},
      '{ROW_BEAT, '0, '0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1, 32'h7FFF_FFFF, 1},
      '{ROW_BEAT, '0, '0, 32'h8000_0000, 32'h1, 32'h0, 32'h0, 1, 32'h8000_0000, 1}
   };

   ldp_value_perturbation dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_gradient_value  (req_gradient_value),
      .req_rand_choice     (req_rand_choice),
      .req_rand_position   (req_rand_position),
      .req_rand_hybrid     (req_rand_hybrid),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_perturbed_value (rsp_perturbed_value),
      .rsp_used_two_point  (rsp_used_two_point),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic perturbation_type perturb_value(logic signed [31:0] grad, logic [31:0] rc,
                                                      logic [31:0] rp, logic [31:0] rh);
      perturbation_type rep;
      longint           x, p, c, prod, offs, g1, g2, lo, hi, r, p1, choice;
      longint unsigned  w, pos;
      x = grad;
      if (x > Q_ONE) x = Q_ONE;
      if (x < -Q_ONE) x = -Q_ONE;
      choice = longint'({32'b0, rc});
      rep.two_point = cfg_mech && (rh <= cfg_hybrid_prob);
      if (rep.two_point) begin
         p = 64'sh8000_0000 + ((x * longint'({32'b0, cfg_tp_slope})) >>> 16);
         if (p < 0) p = 0;
         if (p > 64'sh1_0000_0000) p = 64'sh1_0000_0000;
         r = (choice <= p) ? longint'({32'b0, cfg_tp_mag}) : -longint'({32'b0, cfg_tp_mag});
      end else begin
         c = longint'({32'b0, cfg_pm_bound});
         p1 = ((x + Q_ONE) * longint'({33'b0, cfg_pm_edge})) >>> 16;
         prod = (c + Q_ONE) * x;
         offs = (c - Q_ONE) * Q_ONE;
         g1 = (prod - offs) >>> 17;
         g2 = (prod + offs) >>> 17;
         if (choice < p1) begin
            lo = -c;
            hi = g1;
         end else if (choice < p1 + longint'({32'b0, cfg_pm_center})) begin
            lo = g1;
            hi = g2;
         end else begin
            lo = g2;
            hi = c;
         end
         w = (hi > lo) ? hi - lo : 0;
         pos = (w >> 32) * rp + (((w & 64'hFFFF_FFFF) * rp) >> 32);
         r = lo + longint'(pos);
      end
      if (r > 64'sd2147483647)
         rep.value = SAT_MAX;
      else if (r < -64'sd2147483648)
         rep.value = SAT_MIN;
      else
         rep.value = r[31:0];
      return rep;
   endfunction

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [32:0] pick_value(logic [32:0] low, logic [32:0] high);
      longint unsigned span;
      span = high - low + 1;
      case ($urandom_range(0, 5))
         0: return low;
         1: return high;
         2: return 33'(low + ({$urandom, $urandom} % ((span < 1024) ? span : 1024)));
         default: return 33'(low + ({$urandom, $urandom} % span));
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_beat(logic signed [31:0] grad, logic [31:0] rc, logic [31:0] rp,
                            logic [31:0] rh, bit typed, perturbation_type typed_report);
      req_valid <= 1'b1;
      req_gradient_value <= grad;
      req_rand_choice <= rc;
      req_rand_position <= rp;
      req_rand_hybrid <= rh;
      do @(posedge clock); while (!req_ready);
      if (typed)
         expected_reports = {expected_reports, typed_report};
      else
         expected_reports = {expected_reports, perturb_value(grad, rc, rp, rh)};
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_MECHANISM_SELECT: cfg_mech = value[0];
         CSR_HYBRID_PROB:      cfg_hybrid_prob = value[32:0];
         CSR_TP_MAGNITUDE:     cfg_tp_mag = value[31:0];
         CSR_TP_SLOPE:         cfg_tp_slope = value[31:0];
         CSR_PM_BOUND:         cfg_pm_bound = value[31:0];
         CSR_PM_EDGE_SCALE:    cfg_pm_edge = value[30:0];
         CSR_PM_CENTER_PROB:   cfg_pm_center = value[31:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_phase(int phase);
      real         eps, e, z;
      logic [32:0] mech, prob, mag, slope, bound, edge_scale, center;
      if (phase == 1) begin
         mech = 0; prob = 0; mag = 0; slope = 0;
         bound = Q_ONE; edge_scale = 0; center = 0;
      end else if (phase == NUM_PHASES - 1) begin
         mech = 1; prob = 33'h1_0000_0000; mag = 33'h0_FFFF_FFFF; slope = 33'h0_8000_0000;
         bound = 33'h0_FFFF_FFFF; edge_scale = 33'h0_4000_0000; center = 33'h0_FFFF_FFFF;
      end else if (phase % 2 == 0) begin
         eps = 0.1 + $urandom_range(0, 79) / 10.0;
         e = $exp(eps);
         z = $exp(eps / 2.0);
         mech = (phase % 4 == 0) ? 0 : 1;
         prob = (eps < 0.61) ? 33'h1_0000_0000
                             : 33'(longint'($exp(-eps / 2.0) * 4294967296.0));
         mag = 33'(longint'((e + 1.0) / (e - 1.0) * 65536.0));
         slope = 33'(longint'((e - 1.0) / (2.0 * (e + 1.0)) * 4294967296.0));
         bound = 33'(longint'((z + 1.0) / (z - 1.0) * 65536.0));
         edge_scale = 33'(longint'(1.0 / (2.0 + 2.0 * z) * 4294967296.0));
         center = 33'(longint'(z / (z + 1.0) * 4294967296.0));
      end else begin
         mech = pick_value(0, 1);
         prob = pick_value(0, 33'h1_0000_0000);
         mag = pick_value(0, 33'h0_FFFF_FFFF);
         slope = pick_value(0, 33'h0_8000_0000);
         bound = pick_value(Q_ONE, 33'h0_FFFF_FFFF);
         edge_scale = pick_value(0, 33'h0_4000_0000);
         center = pick_value(0, 33'h0_FFFF_FFFF);
      end
      write_register(CSR_MECHANISM_SELECT, mech);
      write_register(CSR_HYBRID_PROB, prob);
      write_register(CSR_TP_MAGNITUDE, mag);
      write_register(CSR_TP_SLOPE, slope);
      write_register(CSR_PM_BOUND, bound);
      write_register(CSR_PM_EDGE_SCALE, edge_scale);
      write_register(CSR_PM_CENTER_PROB, center);
   endtask

   always @(posedge clock) begin
      perturbation_type oldest;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected beat: perturbed_value %h used_two_point %b",
                   rsp_perturbed_value, rsp_used_two_point);
            mismatch_count++;
         end else begin
            oldest = expected_reports.pop_front();
            if (rsp_perturbed_value !== oldest.value) begin
               $error("perturbed_value: expected %h, got %h", oldest.value, rsp_perturbed_value);
               mismatch_count++;
            end
            if (rsp_used_two_point !== oldest.two_point) begin
               $error("used_two_point: expected %b, got %b", oldest.two_point,
                      rsp_used_two_point);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int run, stall;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
   end

   initial begin
      #(8_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic signed [31:0] grad;
      logic [31:0]        rc, rp, rh;
      bit                 gaps_on;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain();
            write_register(directed_rows[i].index, directed_rows[i].data);
         end else begin
            idle_sender(draw_gap());
            send_beat(directed_rows[i].grad, directed_rows[i].rc, directed_rows[i].rp,
                      directed_rows[i].rh, directed_rows[i].typed,
                      '{value: directed_rows[i].report, two_point: directed_rows[i].two_point});
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         configure_phase(phase);
         gaps_on = (phase % 3 != 2);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               0: grad = $urandom;
               1: grad = ($urandom_range(0, 1) ? 32'sd65536 : -32'sd65536)
                         + $signed($urandom_range(0, 2)) - 1;
               default: grad = $urandom_range(0, 131072) - 65536;
            endcase
            rc = pick_word();
            rp = pick_word();
            rh = ($urandom_range(0, 15) == 0) ? cfg_hybrid_prob[31:0] : pick_word();
            if (gaps_on) idle_sender(draw_gap());
            send_beat(grad, rc, rp, rh, 0, '0);
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
